[design/ssp_pkg.sv]
// ---------------------------------------------------------------------------
// ssp_pkg: shared types and constants for the shortest path engine
// Field widths, request and register codes, controller command/status words.
// ---------------------------------------------------------------------------
package ssp_pkg;

  localparam int VTX_W       = 7;
  localparam int DIST_W      = 32;
  localparam int WIN_W       = 16;
  localparam int REQ_W       = 2;
  localparam int CFG_ADDR_W  = 1;
  localparam int CFG_DATA_W  = 7;
  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_TUSER_W = 2;

  localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_RUN   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  localparam logic [CFG_ADDR_W-1:0] CFG_VERTEX_COUNT  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SOURCE_VERTEX = 1'b1;

  localparam logic [VTX_W-1:0] VC_RESET  = 7'd64;
  localparam logic [VTX_W-1:0] SRC_RESET = 7'd1;

  localparam logic signed [DIST_W-1:0] DIST_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DIST_W-1:0] DIST_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic load_edge;
    logic clear_edges;
    logic run_init;
    logic edge_fetch;
    logic dist_read;
    logic relax;
    logic edge_next;
    logic vtx_next;
    logic vtx_read;
    logic emit_vtx;
    logic emit_cycle;
  } cmd_t;

  typedef struct packed {
    logic edges_empty;
    logic edge_last;
    logic check_pass;
    logic cycle_found;
    logic vtx_skip;
    logic vtx_last;
    logic out_free;
  } sts_t;

endpackage

[design/ssp_datapath.sv]
// ---------------------------------------------------------------------------
// ssp_datapath: edge store, distance store and relaxation unit
// Holds the configuration, the edge and distance memories, the reach marks,
// the pass counters and the result register.
// ---------------------------------------------------------------------------
module ssp_datapath #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 256,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [ssp_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [ssp_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic [ssp_pkg::VTX_W-1:0]           in_edge_from,
  input  logic [ssp_pkg::VTX_W-1:0]           in_edge_to,
  input  logic signed [ssp_pkg::WIN_W-1:0]    in_edge_weight,
  input  ssp_pkg::cmd_t                       cmd,
  output ssp_pkg::sts_t                       sts,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [ssp_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic [ssp_pkg::OUT_TUSER_W-1:0]     out_tuser,
  output logic                                out_tlast
);

  localparam int VW  = ssp_pkg::VTX_W;
  localparam int DW  = ssp_pkg::DIST_W;
  localparam int VIW = $clog2(MAX_VERTICES + 1);
  localparam int ETW = $clog2(MAX_EDGES + 1);
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EW  = 2 * VW + WEIGHT_BITS;
  localparam int CW  = DW + 1;
  localparam logic [VW-1:0]  VC_CAP   = VW'(MAX_VERTICES);
  localparam logic [ETW-1:0] EDGE_CAP = ETW'(MAX_EDGES);

  // configuration
  logic [VW-1:0] vertex_count_r;
  logic [VW-1:0] source_vertex_r;
  logic [VW-1:0] vc;
  logic [VW-1:0] src;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_count_r  <= ssp_pkg::VC_RESET;
      source_vertex_r <= ssp_pkg::SRC_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        ssp_pkg::CFG_VERTEX_COUNT:  vertex_count_r  <= cfg_wdata;
        ssp_pkg::CFG_SOURCE_VERTEX: source_vertex_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    vc = vertex_count_r;
    if (vertex_count_r == '0) begin
      vc = VW'(1);
    end else if (int'(vertex_count_r) > MAX_VERTICES) begin
      vc = VC_CAP;
    end
    src = source_vertex_r;
    if (source_vertex_r == '0) begin
      src = VW'(1);
    end else if (source_vertex_r > vc) begin
      src = vc;
    end
  end

  // edge store
  logic [EW-1:0]          edge_mem [0:MAX_EDGES-1];
  logic [ETW-1:0]         edge_total_r;
  logic                   overflow_r;
  logic                   store_full;
  logic [WEIGHT_BITS-1:0] w_in;
  logic [EW-1:0]          edge_rd_r;
  logic [EAW-1:0]         edge_idx_r;

  assign store_full = (edge_total_r == EDGE_CAP);
  // weight is taken from the low WEIGHT_BITS bits of the zero-extended field
  assign w_in = WEIGHT_BITS'({{(32 - ssp_pkg::WIN_W){1'b0}}, in_edge_weight});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_total_r <= '0;
      overflow_r   <= 1'b0;
    end else if (cmd.clear_edges) begin
      edge_total_r <= '0;
      overflow_r   <= 1'b0;
    end else if (cmd.load_edge) begin
      if (store_full) begin
        overflow_r <= 1'b1;
      end else begin
        edge_total_r <= edge_total_r + ETW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_edge && !store_full) begin
      edge_mem[edge_total_r[EAW-1:0]] <= {in_edge_from, in_edge_to, w_in};
    end
    if (cmd.edge_fetch) begin
      edge_rd_r <= edge_mem[edge_idx_r];
    end
  end

  logic [VW-1:0]                 e_from;
  logic [VW-1:0]                 e_to;
  logic signed [WEIGHT_BITS-1:0] e_w;

  assign e_from = edge_rd_r[EW-1 -: VW];
  assign e_to   = edge_rd_r[EW-VW-1 -: VW];
  assign e_w    = signed'(edge_rd_r[WEIGHT_BITS-1:0]);

  // pass counters
  logic [VW-1:0] round_r;
  logic [VW-1:0] vtx_r;
  logic          cycle_r;
  logic          edge_last;
  logic          check_pass;

  assign edge_last  = ((ETW'(edge_idx_r) + ETW'(1)) == edge_total_r);
  assign check_pass = (round_r == vc);

  // distance store and reach marks
  logic signed [DW-1:0] dist_mem [0:MAX_VERTICES];
  logic [MAX_VERTICES:0] mark_r;
  logic signed [DW-1:0] d_a_r;
  logic signed [DW-1:0] d_to_r;
  logic [VW-1:0]        rd_a_vtx;
  logic                 from_ok;
  logic                 to_ok;
  logic                 mark_from;
  logic                 mark_to;
  logic                 mark_vtx;
  logic signed [CW-1:0] cand;
  logic                 better;
  logic                 hit;
  logic signed [DW-1:0] cand_sat;
  logic                 dist_we;
  logic [VIW-1:0]       dist_wa;
  logic signed [DW-1:0] dist_wd;

  assign from_ok   = (e_from != '0) && (e_from <= vc);
  assign to_ok     = (e_to != '0) && (e_to <= vc);
  assign mark_from = from_ok && mark_r[VIW'(e_from)];
  assign mark_to   = to_ok && mark_r[VIW'(e_to)];
  assign mark_vtx  = mark_r[VIW'(vtx_r)];

  // exact sum, then clip to 32 bits only when it is stored
  assign cand     = CW'(d_a_r) + CW'(e_w);
  assign better   = !mark_to || (CW'(d_to_r) > cand);
  assign hit      = from_ok && to_ok && mark_from && better;
  assign cand_sat = (cand[CW-1] != cand[CW-2]) ?
                    (cand[CW-1] ? ssp_pkg::DIST_MIN : ssp_pkg::DIST_MAX) :
                    cand[DW-1:0];

  assign rd_a_vtx = cmd.vtx_read ? vtx_r : e_from;

  always_comb begin
    dist_we = 1'b0;
    dist_wa = VIW'(src);
    dist_wd = '0;
    if (cmd.run_init) begin
      dist_we = 1'b1;
    end else if (cmd.relax && !check_pass && hit) begin
      dist_we = 1'b1;
      dist_wa = VIW'(e_to);
      dist_wd = cand_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (dist_we) begin
      dist_mem[dist_wa] <= dist_wd;
    end
    if (cmd.dist_read || cmd.vtx_read) begin
      d_a_r <= dist_mem[VIW'(rd_a_vtx)];
    end
    if (cmd.dist_read) begin
      d_to_r <= dist_mem[VIW'(e_to)];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.run_init) begin
      mark_r              <= {{MAX_VERTICES{1'b0}}, 1'b1} << src;
    end else if (cmd.relax && !check_pass && hit) begin
      mark_r[VIW'(e_to)]  <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_idx_r <= '0;
      round_r    <= '0;
      vtx_r      <= '0;
      cycle_r    <= 1'b0;
    end else begin
      if (cmd.run_init) begin
        edge_idx_r <= '0;
        round_r    <= VW'(1);
        vtx_r      <= VW'(1);
        cycle_r    <= 1'b0;
      end else begin
        if (cmd.edge_next) begin
          if (edge_last) begin
            edge_idx_r <= '0;
            round_r    <= round_r + VW'(1);
          end else begin
            edge_idx_r <= edge_idx_r + EAW'(1);
          end
        end
        if (cmd.vtx_next || cmd.emit_vtx) begin
          vtx_r <= vtx_r + VW'(1);
        end
        if (cmd.relax && check_pass && hit) begin
          cycle_r <= 1'b1;
        end
      end
    end
  end

  // result register
  logic                 out_valid_r;
  logic [VW-1:0]        out_vertex_r;
  logic signed [DW-1:0] out_dist_r;
  logic                 out_unreach_r;
  logic                 out_negc_r;
  logic                 out_drop_r;
  logic                 out_last_r;
  logic                 out_free;
  logic                 vtx_final;

  assign out_free  = !out_valid_r || out_tready;
  // last reported vertex is vc, or vc-1 when the source is vc
  assign vtx_final = (vtx_r == vc) || (((vtx_r + VW'(1)) == vc) && (src == vc));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_vtx || cmd.emit_cycle) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_vtx) begin
      out_vertex_r  <= vtx_r;
      out_dist_r    <= mark_vtx ? d_a_r : '0;
      out_unreach_r <= !mark_vtx;
      out_negc_r    <= 1'b0;
      out_drop_r    <= overflow_r;
      out_last_r    <= vtx_final;
    end else if (cmd.emit_cycle) begin
      out_vertex_r  <= '0;
      out_dist_r    <= '0;
      out_unreach_r <= 1'b0;
      out_negc_r    <= 1'b1;
      out_drop_r    <= overflow_r;
      out_last_r    <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_drop_r, out_dist_r, out_vertex_r};
  assign out_tuser  = {out_negc_r, out_unreach_r};
  assign out_tlast  = out_last_r;

  assign sts.edges_empty = (edge_total_r == '0);
  assign sts.edge_last   = edge_last;
  assign sts.check_pass  = check_pass;
  assign sts.cycle_found = cycle_r;
  assign sts.vtx_skip    = (vtx_r == src);
  assign sts.vtx_last    = (vtx_r == vc);
  assign sts.out_free    = out_free;

endmodule

[design/ssp_ctrl.sv]
// ---------------------------------------------------------------------------
// ssp_ctrl: sequencer for load, clear, relaxation passes and reporting
// Walks each edge in three steps (fetch, read distances, relax) and then
// reports one vertex at a time, or one negative cycle, into the result register.
// ---------------------------------------------------------------------------
module ssp_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [ssp_pkg::REQ_W-1:0]  req_type,
  input  ssp_pkg::sts_t              sts,
  output ssp_pkg::cmd_t              cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FETCH  = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_EVAL   = 3'd3;
  localparam logic [2:0] S_DECIDE = 3'd4;
  localparam logic [2:0] S_VSEL   = 3'd5;
  localparam logic [2:0] S_VPUT   = 3'd6;
  localparam logic [2:0] S_NEGC   = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          case (req_type)
            ssp_pkg::REQ_LOAD:  cmd.load_edge = 1'b1;
            ssp_pkg::REQ_CLEAR: cmd.clear_edges = 1'b1;
            ssp_pkg::REQ_RUN: begin
              cmd.run_init = 1'b1;
              state_nxt    = sts.edges_empty ? S_VSEL : S_FETCH;
            end
            default: ;
          endcase
        end
      end
      S_FETCH: begin
        cmd.edge_fetch = 1'b1;
        state_nxt      = S_READ;
      end
      S_READ: begin
        cmd.dist_read = 1'b1;
        state_nxt     = S_EVAL;
      end
      S_EVAL: begin
        cmd.relax     = 1'b1;
        cmd.edge_next = 1'b1;
        // the cycle flag of the final check edge is registered here and read in S_DECIDE
        state_nxt = (sts.edge_last && sts.check_pass) ? S_DECIDE : S_FETCH;
      end
      S_DECIDE: begin
        state_nxt = sts.cycle_found ? S_NEGC : S_VSEL;
      end
      S_VSEL: begin
        if (sts.vtx_skip) begin
          if (sts.vtx_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.vtx_next = 1'b1;
          end
        end else begin
          cmd.vtx_read = 1'b1;
          state_nxt    = S_VPUT;
        end
      end
      S_VPUT: begin
        if (sts.out_free) begin
          cmd.emit_vtx = 1'b1;
          state_nxt    = sts.vtx_last ? S_IDLE : S_VSEL;
        end
      end
      S_NEGC: begin
        if (sts.out_free) begin
          cmd.emit_cycle = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

[design/single_source_shortest_path.sv]
// ---------------------------------------------------------------------------
// single_source_shortest_path: Bellman-Ford shortest path engine
// Edge store with load/clear, relaxation passes and per-vertex reporting.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : request stream. in_tuser = request kind (load, run, clear).
//           Load appends an edge; clear empties the store.
//   out_* : one result per non-source vertex, ascending, tlast on the final
//           one; or a single negative-cycle result. Load/clear give nothing.
//   cfg_* : vertex count and source vertex, written while the block is idle.
// Operation:
//   A run with V vertices makes V-1 relaxation passes over the stored edges
//   and then a check pass, each edge going through the three-step edge loop
//   (edge read, distance read, relax and write) around the single-write
//   distance memory; then each non-source vertex is read and reported in
//   turn. One request in flight.
// Reset: edge store empty, no drop flag, vertex count 64, source vertex 1.
// Back-pressure: the result register holds while out_tready is low and the
//   sequencer waits; in_tready stays low until the run has been reported.
// ---------------------------------------------------------------------------
module single_source_shortest_path #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 256,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [ssp_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [ssp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // edge_from [6:0], edge_to [13:7], edge_weight [29:14], zero [31:30]
  input  logic [ssp_pkg::IN_TDATA_W-1:0]   in_tdata,
  // req_type [1:0]
  input  logic [ssp_pkg::IN_TUSER_W-1:0]   in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // vertex [6:0], distance [38:7], edges_dropped [39]
  output logic [ssp_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // unreachable [0], negative_cycle [1]
  output logic [ssp_pkg::OUT_TUSER_W-1:0]  out_tuser,
  output logic                             out_tlast
);

  localparam int VW = ssp_pkg::VTX_W;
  localparam int WW = ssp_pkg::WIN_W;

  ssp_pkg::cmd_t cmd;
  ssp_pkg::sts_t sts;

  logic [VW-1:0]        edge_from;
  logic [VW-1:0]        edge_to;
  logic signed [WW-1:0] edge_weight;

  assign edge_from   = in_tdata[VW-1:0];
  assign edge_to     = in_tdata[2*VW-1:VW];
  assign edge_weight = signed'(in_tdata[2*VW+WW-1:2*VW]);

  ssp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .req_type  (in_tuser),
    .sts       (sts),
    .cmd       (cmd)
  );

  ssp_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .in_edge_from   (edge_from),
    .in_edge_to     (edge_to),
    .in_edge_weight (edge_weight),
    .cmd            (cmd),
    .sts            (sts),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .out_tlast      (out_tlast)
  );

endmodule

[tb/single_source_shortest_path_tb.sv]
// ---------------------------------------------------------------------------
// single_source_shortest_path_tb: regression for the shortest path engine
// Loads edge sets, runs Bellman-Ford passes under several vertex counts and
// sources, and checks every distance report against a behavioural predictor.
// Both stream sides idle and stall at random.
// ---------------------------------------------------------------------------
module single_source_shortest_path_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_VERTICES = 64;
  localparam int MAX_EDGES    = 256;
  localparam int RANDOM_ITEMS = 100;
  localparam int QUIET_LIMIT  = 200000;
  localparam int MAX_GAP      = 18;
  localparam int VW           = ssp_pkg::VTX_W;
  localparam int WW           = ssp_pkg::WIN_W;

  // request code the block must ignore
  localparam logic [ssp_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct {
    logic [ssp_pkg::VTX_W-1:0]         vertex;
    logic signed [ssp_pkg::DIST_W-1:0] distance;
    logic                              unreachable;
    logic                              neg_cycle;
    logic                              dropped;
    logic                              last;
  } report_t;

  logic                                clk;
  logic                                rst_n;
  logic                                cfg_we;
  logic [ssp_pkg::CFG_ADDR_W-1:0]      cfg_addr;
  logic [ssp_pkg::CFG_DATA_W-1:0]      cfg_wdata;
  logic                                in_tvalid;
  logic                                in_tready;
  // edge_from [6:0], edge_to [13:7], edge_weight [29:14], zero [31:30]
  logic [ssp_pkg::IN_TDATA_W-1:0]      in_tdata;
  // req_type [1:0]
  logic [ssp_pkg::IN_TUSER_W-1:0]      in_tuser;
  logic                                out_tvalid;
  logic                                out_tready;
  // vertex [6:0], distance [38:7], edges_dropped [39]
  logic [ssp_pkg::OUT_TDATA_W-1:0]     out_tdata;
  // unreachable [0], negative_cycle [1]
  logic [ssp_pkg::OUT_TUSER_W-1:0]     out_tuser;
  logic                                out_tlast;

  // predictor state
  logic [ssp_pkg::VTX_W-1:0] edge_src_mem [MAX_EDGES];
  logic [ssp_pkg::VTX_W-1:0] edge_dst_mem [MAX_EDGES];
  int                        edge_wt_mem  [MAX_EDGES];
  int                        edge_count;
  bit                        drop_flag;
  int                        dist_mem     [0:MAX_VERTICES];
  bit                        reached_mem  [0:MAX_VERTICES];
  logic [ssp_pkg::VTX_W-1:0] vcount_reg;
  logic [ssp_pkg::VTX_W-1:0] source_reg;
  int                        settle_cycles;

  report_t pending_reports [$];
  int      mismatch_count;
  int      quiet_cycles;
  int      in_burst;
  int      out_burst;

  single_source_shortest_path dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // idle length per item, with occasional back-to-back stretches
  function automatic int draw_gap(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 6) == 0) burst = $urandom_range(4, 16);
    return $urandom_range(0, MAX_GAP);
  endfunction

  function automatic int clamp_vcount();
    if (vcount_reg < 1) return 1;
    if (vcount_reg > MAX_VERTICES) return MAX_VERTICES;
    return int'(vcount_reg);
  endfunction

  function automatic int sat32(input longint x);
    if (x > longint'(ssp_pkg::DIST_MAX)) return ssp_pkg::DIST_MAX;
    if (x < longint'(ssp_pkg::DIST_MIN)) return ssp_pkg::DIST_MIN;
    return int'(x);
  endfunction

  // true when edge idx lowers the distance of its end vertex
  function automatic bit can_lower(input int idx, input int vc, output longint cand);
    int a;
    int b;
    a = int'(edge_src_mem[idx]);
    b = int'(edge_dst_mem[idx]);
    cand = 0;
    if (a < 1 || a > vc || b < 1 || b > vc) return 1'b0;
    if (!reached_mem[a]) return 1'b0;
    cand = longint'(dist_mem[a]) + longint'(edge_wt_mem[idx]);
    return !reached_mem[b] || longint'(dist_mem[b]) > cand;
  endfunction

  task automatic relax_and_report();
    int      vc;
    int      src;
    bit      cycle;
    longint  cand;
    report_t rep;
    int      first;
    vc  = clamp_vcount();
    src = (source_reg < 1) ? 1 : ((int'(source_reg) > vc) ? vc : int'(source_reg));
    for (int i = 0; i <= MAX_VERTICES; i++) begin
      dist_mem[i]    = 0;
      reached_mem[i] = 1'b0;
    end
    reached_mem[src] = 1'b1;
    for (int r = 1; r < vc; r++) begin
      for (int i = 0; i < edge_count; i++) begin
        if (can_lower(i, vc, cand)) begin
          dist_mem[edge_dst_mem[i]]    = sat32(cand);
          reached_mem[edge_dst_mem[i]] = 1'b1;
        end
      end
    end
    cycle = 1'b0;
    for (int i = 0; i < edge_count; i++)
      if (can_lower(i, vc, cand)) cycle = 1'b1;

    settle_cycles = 16;
    if (cycle) begin
      rep.vertex      = '0;
      rep.distance    = '0;
      rep.unreachable = 1'b0;
      rep.neg_cycle   = 1'b1;
      rep.dropped     = drop_flag;
      rep.last        = 1'b1;
      pending_reports.push_back(rep);
      return;
    end
    first = pending_reports.size();
    for (int v = 1; v <= vc; v++) begin
      if (v == src) continue;
      rep.vertex      = v[ssp_pkg::VTX_W-1:0];
      rep.distance    = reached_mem[v] ? dist_mem[v] : 0;
      rep.unreachable = !reached_mem[v];
      rep.neg_cycle   = 1'b0;
      rep.dropped     = drop_flag;
      rep.last        = 1'b0;
      pending_reports.push_back(rep);
    end
    if (pending_reports.size() > first)
      pending_reports[pending_reports.size() - 1].last = 1'b1;
    else
      // silent run: block may still be in its passes after the last report
      settle_cycles = 3 * (edge_count + 2) * (vc + 1) + 4 * vc + 64;
  endtask

  task automatic apply_request(input logic [ssp_pkg::REQ_W-1:0] req,
                               input logic [ssp_pkg::VTX_W-1:0] from,
                               input logic [ssp_pkg::VTX_W-1:0] to,
                               input logic [ssp_pkg::WIN_W-1:0] w);
    case (req)
      ssp_pkg::REQ_LOAD: begin
        if (edge_count < MAX_EDGES) begin
          edge_src_mem[edge_count] = from;
          edge_dst_mem[edge_count] = to;
          edge_wt_mem[edge_count]  = int'($signed(w));
          edge_count++;
        end else begin
          drop_flag = 1'b1;
        end
      end
      ssp_pkg::REQ_CLEAR: begin
        edge_count = 0;
        drop_flag  = 1'b0;
      end
      ssp_pkg::REQ_RUN: relax_and_report();
      default: ;
    endcase
  endtask

  // one input transfer; entered and left on a rising edge, valid left high
  task automatic send_req(input logic [ssp_pkg::REQ_W-1:0] req,
                          input logic [ssp_pkg::VTX_W-1:0] from,
                          input logic [ssp_pkg::VTX_W-1:0] to,
                          input logic [ssp_pkg::WIN_W-1:0] w);
    int gap;
    gap = draw_gap(in_burst);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, w, to, from};
    in_tuser  <= req;
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
    apply_request(req, from, to, w);
  endtask

  task automatic load_edge(input logic [ssp_pkg::VTX_W-1:0] from,
                           input logic [ssp_pkg::VTX_W-1:0] to,
                           input logic [ssp_pkg::WIN_W-1:0] w);
    send_req(ssp_pkg::REQ_LOAD, from, to, w);
  endtask

  // data fields of non-load requests carry junk the block must ignore
  task automatic send_kind(input logic [ssp_pkg::REQ_W-1:0] req);
    send_req(req, VW'($urandom_range(0, 127)), VW'($urandom_range(0, 127)),
             WW'($urandom_range(0, 65535)));
  endtask

  task automatic settle_block();
    in_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    @(posedge clk);
    repeat (settle_cycles) @(posedge clk);
  endtask

  task automatic write_config(input logic [ssp_pkg::VTX_W-1:0] vc,
                              input logic [ssp_pkg::VTX_W-1:0] src);
    settle_block();
    cfg_we    <= 1'b1;
    cfg_addr  <= ssp_pkg::CFG_VERTEX_COUNT;
    cfg_wdata <= vc;
    @(posedge clk);
    cfg_addr  <= ssp_pkg::CFG_SOURCE_VERTEX;
    cfg_wdata <= src;
    @(posedge clk);
    cfg_we    <= 1'b0;
    vcount_reg = vc;
    source_reg = src;
  endtask

  // reset values: 64 vertices, source 1
  task automatic test_reset_defaults();
    load_edge(7'd1, 7'd2, 16'd5);
    load_edge(7'd2, 7'd64, -16'sd3);
    load_edge(7'd64, 7'd3, 16'sd32767);
    load_edge(7'd1, 7'd64, 16'd10);
    send_kind(ssp_pkg::REQ_RUN);
  endtask

  task automatic test_weight_extremes();
    write_config(7'd4, 7'd2);
    send_kind(ssp_pkg::REQ_CLEAR);
    load_edge(7'd2, 7'd3, -16'sd32768);
    load_edge(7'd3, 7'd4, 16'sd32767);
    load_edge(7'd2, 7'd1, 16'd0);
    // endpoints out of range: kept, never relaxed
    load_edge(7'd0, 7'd3, -16'sd5);
    load_edge(7'd3, 7'd127, -16'sd7);
    load_edge(7'd127, 7'd0, 16'd1);
    send_kind(REQ_UNUSED);
    send_kind(ssp_pkg::REQ_RUN);
    // closes 2->3->4->2 with a negative sum
    load_edge(7'd4, 7'd2, -16'sd32768);
    send_kind(ssp_pkg::REQ_RUN);
    send_kind(ssp_pkg::REQ_CLEAR);
    send_kind(ssp_pkg::REQ_RUN);
  endtask

  task automatic test_config_extremes();
    // vertex count 0 behaves as a single vertex: nothing reported
    write_config(7'd0, 7'd5);
    send_kind(ssp_pkg::REQ_CLEAR);
    load_edge(7'd1, 7'd1, 16'd10);
    send_kind(ssp_pkg::REQ_RUN);
    // count above range clips to 64, source 0 acts as 1
    write_config(7'd127, 7'd0);
    send_kind(ssp_pkg::REQ_RUN);
    // source above count clips to the count
    write_config(7'd3, 7'd127);
    load_edge(7'd3, 7'd1, -16'sd1);
    load_edge(7'd1, 7'd2, -16'sd2);
    send_kind(ssp_pkg::REQ_RUN);
    // single vertex with a negative self loop on the source
    write_config(7'd1, 7'd1);
    load_edge(7'd1, 7'd1, -16'sd1);
    send_kind(ssp_pkg::REQ_RUN);
    // negative cycle that the source cannot reach
    write_config(7'd4, 7'd1);
    send_kind(ssp_pkg::REQ_CLEAR);
    load_edge(7'd2, 7'd3, -16'sd4);
    load_edge(7'd3, 7'd2, 16'd1);
    load_edge(7'd1, 7'd4, 16'd7);
    send_kind(ssp_pkg::REQ_RUN);
  endtask

  task automatic test_store_overflow();
    logic [ssp_pkg::VTX_W-1:0] a;
    logic [ssp_pkg::VTX_W-1:0] b;
    write_config(7'd2, 7'd1);
    send_kind(ssp_pkg::REQ_CLEAR);
    for (int i = 0; i < MAX_EDGES + 4; i++) begin
      a = ($urandom_range(0, 15) == 0) ? VW'($urandom_range(0, 127)) :
                                         VW'($urandom_range(1, 64));
      b = ($urandom_range(0, 15) == 0) ? VW'($urandom_range(0, 127)) :
                                         VW'($urandom_range(1, 64));
      load_edge(a, b, WW'($urandom_range(0, 32767)));
    end
    send_kind(ssp_pkg::REQ_RUN);
    // one run over a full store at the largest size
    write_config(7'd64, 7'd64);
    send_kind(ssp_pkg::REQ_RUN);
    write_config(7'd2, 7'd2);
    send_kind(ssp_pkg::REQ_CLEAR);
    load_edge(7'd2, 7'd1, 16'd9);
    send_kind(ssp_pkg::REQ_RUN);
  endtask

  task automatic test_random_graphs();
    int                        sent;
    int                        eff;
    int                        rounds;
    int                        nedges;
    int                        wmode;
    logic [ssp_pkg::VTX_W-1:0] vc;
    logic [ssp_pkg::VTX_W-1:0] src;
    logic [ssp_pkg::VTX_W-1:0] a;
    logic [ssp_pkg::VTX_W-1:0] b;
    logic [ssp_pkg::WIN_W-1:0] w;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       vc = 7'd0;
        1:       vc = 7'd1;
        2:       vc = 7'd64;
        3:       vc = VW'($urandom_range(65, 127));
        default: vc = VW'($urandom_range(2, 12));
      endcase
      eff = (vc < 1) ? 1 : ((int'(vc) > MAX_VERTICES) ? MAX_VERTICES : int'(vc));
      src = ($urandom_range(0, 4) == 0) ? VW'($urandom_range(0, 127)) :
                                          VW'($urandom_range(1, eff));
      write_config(vc, src);
      send_kind(ssp_pkg::REQ_CLEAR);
      sent++;
      rounds = $urandom_range(1, 3);
      for (int r = 0; r < rounds; r++) begin
        nedges = $urandom_range(1, 10);
        wmode  = $urandom_range(0, 2);
        for (int e = 0; e < nedges; e++) begin
          if ($urandom_range(0, 11) == 0) begin
            send_kind(REQ_UNUSED);
          end else if ($urandom_range(0, 19) == 0) begin
            send_kind(ssp_pkg::REQ_CLEAR);
            sent++;
          end else begin
            a = ($urandom_range(0, 9) == 0) ? VW'($urandom_range(0, 127)) :
                                              VW'($urandom_range(1, eff));
            b = ($urandom_range(0, 9) == 0) ? VW'($urandom_range(0, 127)) :
                                              VW'($urandom_range(1, eff));
            case (wmode)
              0:       w = WW'($urandom_range(0, 65535));
              1:       w = WW'($urandom_range(0, 200));
              default: w = WW'($urandom_range(0, 400) - 100);
            endcase
            load_edge(a, b, w);
            sent++;
          end
        end
        send_kind(ssp_pkg::REQ_RUN);
        sent++;
      end
    end
  endtask

  task automatic compare_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // sampled mid-cycle: a report seen here transfers at the next rising edge
  always @(negedge clk) begin : report_check
    report_t got;
    report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.vertex      = out_tdata[6:0];
      got.distance    = out_tdata[38:7];
      got.dropped     = out_tdata[39];
      got.unreachable = out_tuser[0];
      got.neg_cycle   = out_tuser[1];
      got.last        = out_tlast;
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected report: expected none, actual vertex %0d distance %0d",
                 $time, got.vertex, got.distance);
        mismatch_count++;
      end else begin
        want = pending_reports.pop_front();
        compare_field("vertex", want.vertex, got.vertex);
        compare_field("distance", want.distance, got.distance);
        compare_field("unreachable", want.unreachable, got.unreachable);
        compare_field("negative_cycle", want.neg_cycle, got.neg_cycle);
        compare_field("edges_dropped", want.dropped, got.dropped);
        compare_field("last", want.last, got.last);
      end
    end
  end

  always @(negedge clk) begin : watchdog
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
          $display("single_source_shortest_path regression: fail");
          $finish;
        end
      end
    end
  end

  // result side back-pressure
  initial begin : result_sink
    int stall;
    out_tready = 1'b0;
    out_burst  = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = draw_gap(out_burst);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(negedge clk); while (!out_tvalid);
      @(posedge clk);
    end
  end

  initial begin : stimulus
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_addr       = '0;
    cfg_wdata      = '0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = '0;
    edge_count     = 0;
    drop_flag      = 1'b0;
    vcount_reg     = ssp_pkg::VC_RESET;
    source_reg     = ssp_pkg::SRC_RESET;
    settle_cycles  = 16;
    mismatch_count = 0;
    quiet_cycles   = 0;
    in_burst       = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_weight_extremes();
    test_config_extremes();
    test_store_overflow();
    test_random_graphs();

    settle_block();
    repeat (64) @(posedge clk);
    if (mismatch_count == 0 && pending_reports.size() == 0) begin
      $display("single_source_shortest_path regression: pass");
    end else begin
      $display("single_source_shortest_path regression: fail");
    end
    $finish;
  end

endmodule
